// File: src/ttbc_pkg.sv
// ----------------------------------------------------------------------------
// ttbc_pkg
// Shared types and constants for the tap tempo beat clock: the item function
// codes, register indexes, sequencer states and the divider interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ttbc_pkg;

  // Channel count and the width of a channel index.
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;

  // Milliseconds per minute; the dividend of every division.
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam int          DIV_STEPS     = 16;
  localparam int          DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [7:0] TAP_COUNT_MAX = 8'd255;

  // Register reset values.
  localparam logic [9:0] MIN_BPM_RST     = 10'd40;
  localparam logic [9:0] MAX_BPM_RST     = 10'd300;
  localparam logic [7:0] PULSE_LEN_RST   = 8'd70;
  localparam logic [3:0] CATCHUP_RST     = 4'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_BPM   = 2'd0;
  localparam logic [1:0] REG_MAX_BPM   = 2'd1;
  localparam logic [1:0] REG_PULSE_LEN = 2'd2;
  localparam logic [1:0] REG_CATCHUP   = 2'd3;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_TAP       = 2'd0,
    FUNC_TICK      = 2'd1,
    FUNC_DISABLE   = 2'd2,
    FUNC_RESET_ALL = 2'd3
  } ttbc_func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_TAP_BPM,
    ST_TAP_PER,
    ST_TICK_CHECK,
    ST_TICK_DIV,
    ST_CLEAR,
    ST_FINISH
  } ttbc_state_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] divisor;
  } ttbc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } ttbc_div_rsp_t;

endpackage

`default_nettype wire

// File: src/tap_tempo_beat_clock.sv
// Each division of 60000 runs on the one shared restoring divider;
// a tap needs up to two and a tick one for each channel whose beat is due.
// Throughput: one item at a time; the next item is taken once this one's
// result is in the output register. Reset clears all channels and loads the
// register defaults.
// ----------------------------------------------------------------------------
// tap_tempo_beat_clock
// Four-channel tap tempo clock: taps set a tempo, ticks emit beat pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_beat_clock
  import ttbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // channel[1:0], now_ms[33:2], enable_mask[37:34]
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  // Result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // tempo_set[0], new_bpm[10:1], led_pulse_mask[14:11],
                                      // pulse_ms[22:15], channel_bpm[32:23], any_bpm[42:33]
  // Configuration writes
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [9:0]  wr_data
);

  // Configuration registers
  logic [9:0] min_bpm;
  logic [9:0] max_bpm;
  logic [7:0] pulse_length_ms;
  logic [3:0] catchup_periods;

  // Channel state
  logic [7:0]  tap_count      [NUM_CHANNELS];
  logic [31:0] last_tap_time  [NUM_CHANNELS];
  logic [9:0]  tempo_bpm      [NUM_CHANNELS];
  logic [31:0] next_beat_time [NUM_CHANNELS];

  // Current item and working registers
  ttbc_state_t       state, state_next;
  ttbc_func_t        cur_func;
  logic [CH_W-1:0]   cur_ch;
  logic [31:0]       cur_now;
  logic [3:0]        cur_mask;
  logic [CH_W-1:0]   idx;
  logic [9:0]        bpm_reg;
  logic [9:0]        res_new;
  logic [3:0]        res_pulses;

  ttbc_div_req_t div_req;
  ttbc_div_rsp_t div_rsp;

  logic        in_accept;
  logic        out_free;
  logic [7:0]  cnt_cur;
  logic [31:0] last_cur;
  logic [31:0] delta;
  logic        tap_restart;
  logic        bpm_bad;
  logic [7:0]  cnt_sat;
  logic [31:0] lag;
  logic        beat_due;
  logic [19:0] catch_lim;
  logic        idx_last;
  logic [9:0]  chan_bpm;
  logic [9:0]  any_bpm;
  logic [7:0]  pulse_ms;
  logic [47:0] out_word;

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  ttbc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Tap arithmetic on the addressed channel.
  assign cnt_cur     = tap_count[cur_ch];
  assign last_cur    = last_tap_time[cur_ch];
  assign delta       = cur_now - last_cur;
  assign tap_restart = (cnt_cur == 8'd0) || (cur_now < last_cur);
  assign cnt_sat     = (cnt_cur == TAP_COUNT_MAX) ? cnt_cur : cnt_cur + 8'd1;
  assign bpm_bad     = (div_rsp.quotient < {6'd0, min_bpm})
                    || (div_rsp.quotient > {6'd0, max_bpm})
                    || (div_rsp.quotient == 16'd0);

  // Beat check on the channel the tick loop points at.
  assign lag       = cur_now - next_beat_time[idx];
  assign beat_due  = cur_mask[idx] && (tempo_bpm[idx] != 10'd0) && !lag[31];
  assign catch_lim = {4'd0, div_rsp.quotient} * {16'd0, catchup_periods};
  assign idx_last  = idx == CH_W'(NUM_CHANNELS - 1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (ttbc_func_t'(s_tuser))
            FUNC_TAP:  state_next = ST_TAP;
            FUNC_TICK: state_next = ST_TICK_CHECK;
            default:   state_next = ST_CLEAR;
          endcase
        end
      end
      ST_TAP: begin
        if (tap_restart || delta == 32'd0) state_next = ST_FINISH;
        else                               state_next = ST_TAP_BPM;
      end
      ST_TAP_BPM: begin
        if (div_rsp.done) state_next = bpm_bad ? ST_FINISH : ST_TAP_PER;
      end
      ST_TAP_PER: begin
        if (div_rsp.done) state_next = ST_FINISH;
      end
      ST_TICK_CHECK: begin
        if (beat_due)      state_next = ST_TICK_DIV;
        else if (idx_last) state_next = ST_FINISH;
      end
      ST_TICK_DIV: begin
        if (div_rsp.done) state_next = idx_last ? ST_FINISH : ST_TICK_CHECK;
      end
      ST_CLEAR: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider requests.
  always_comb begin
    s_tready        = state == ST_IDLE;
    div_req.start   = 1'b0;
    div_req.divisor = delta;
    case (state)
      ST_TAP: begin
        div_req.start = !tap_restart && (delta != 32'd0);
      end
      ST_TAP_BPM: begin
        div_req.start   = div_rsp.done && !bpm_bad;
        div_req.divisor = {22'd0, div_rsp.quotient[9:0]};
      end
      ST_TICK_CHECK: begin
        div_req.start   = beat_due;
        div_req.divisor = {22'd0, tempo_bpm[idx]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_bpm         <= MIN_BPM_RST;
      max_bpm         <= MAX_BPM_RST;
      pulse_length_ms <= PULSE_LEN_RST;
      catchup_periods <= CATCHUP_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_MIN_BPM:   min_bpm         <= wr_data;
        REG_MAX_BPM:   max_bpm         <= wr_data;
        REG_PULSE_LEN: pulse_length_ms <= wr_data[7:0];
        REG_CATCHUP:   catchup_periods <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // Item capture and loop index.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_func <= ttbc_func_t'(s_tuser);
      cur_ch   <= s_tdata[1:0];
      cur_now  <= s_tdata[33:2];
      cur_mask <= s_tdata[37:34];
    end
    if (state == ST_TAP_BPM && div_rsp.done) bpm_reg <= div_rsp.quotient[9:0];
  end

  // Channel state and result accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        tap_count[i]      <= '0;
        last_tap_time[i]  <= '0;
        tempo_bpm[i]      <= '0;
        next_beat_time[i] <= '0;
      end
      idx        <= '0;
      res_new    <= '0;
      res_pulses <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            idx        <= '0;
            res_new    <= '0;
            res_pulses <= '0;
          end
        end
        ST_TAP: begin
          last_tap_time[cur_ch] <= cur_now;
          if (tap_restart || delta == 32'd0) tap_count[cur_ch] <= 8'd1;
        end
        ST_TAP_BPM: begin
          if (div_rsp.done) tap_count[cur_ch] <= bpm_bad ? 8'd1 : cnt_sat;
        end
        ST_TAP_PER: begin
          if (div_rsp.done) begin
            tempo_bpm[cur_ch]      <= bpm_reg;
            next_beat_time[cur_ch] <= cur_now + {16'd0, div_rsp.quotient};
            res_new                <= bpm_reg;
            res_pulses[cur_ch]     <= 1'b1;
          end
        end
        ST_TICK_CHECK: begin
          if (!beat_due && !idx_last) idx <= idx + 1'b1;
        end
        ST_TICK_DIV: begin
          if (div_rsp.done) begin
            res_pulses[idx] <= 1'b1;
            // Resync to now after too long a lag, else keep the beat grid.
            if (lag > {12'd0, catch_lim})
              next_beat_time[idx] <= cur_now + {16'd0, div_rsp.quotient};
            else
              next_beat_time[idx] <= next_beat_time[idx] + {16'd0, div_rsp.quotient};
            if (!idx_last) idx <= idx + 1'b1;
          end
        end
        ST_CLEAR: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (cur_func == FUNC_RESET_ALL || cur_ch == CH_W'(i)) begin
              tap_count[i]      <= '0;
              last_tap_time[i]  <= '0;
              tempo_bpm[i]      <= '0;
              next_beat_time[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields read after the item's updates.
  always_comb begin
    chan_bpm = tempo_bpm[cur_ch];
    any_bpm  = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (cur_mask[i] && tempo_bpm[i] != 10'd0) any_bpm = tempo_bpm[i];
    end
    pulse_ms = (res_pulses != 4'd0) ? pulse_length_ms : 8'd0;
    out_word = {5'd0, any_bpm, chan_bpm, pulse_ms, res_pulses, res_new,
                res_new != 10'd0};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) m_tdata <= out_word;
  end

`ifndef SYNTHESIS
  // The divider only reports back to a state that waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_TAP_BPM || state == ST_TAP_PER || state == ST_TICK_DIV))
    else $error("divider result arrived with no one waiting");

  // A new tempo is flagged exactly when a nonzero tempo is reported.
  a_tempo_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[10:1] != 10'd0)))
    else $error("tempo_set disagrees with new_bpm");

  // A pulse length is reported only alongside pulses.
  a_pulse_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[14:11] == 4'd0) |-> (m_tdata[22:15] == 8'd0))
    else $error("pulse length without pulses");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in work");
`endif

endmodule

`default_nettype wire

// File: src/ttbc_div.sv
// ----------------------------------------------------------------------------
// ttbc_div
// Restoring divider that computes 60000 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttbc_div
  import ttbc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ttbc_div_req_t req,
  output ttbc_div_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          divisor;
  logic [31:0]          rem;
  logic [15:0]          quot;
  logic [32:0]          trial;
  logic                 fits;

  // One step: bring down the next dividend bit and try a subtract.
  assign trial = {rem, quot[15]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register; dividend bits leave at the top.
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quot    <= MS_PER_MINUTE;
    end else if (busy) begin
      rem  <= fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      quot <= {quot[14:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-channel tap tempo beat clock. A scoreboard
// object mirrors the channel state, predicts one result for every accepted
// input item and checks the result stream field by field. Stimulus is a short
// directed sequence followed by random tap bursts, tick runs, broken taps and
// noise under several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------

module tb;
  import ttbc_pkg::*;

  localparam logic [31:0] MINUTE_MS   = 32'd60000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          MAX_REPORTS = 10;

  // Fields of one result item, lowest bits declared last.
  typedef struct packed {
    logic [9:0] any_bpm;
    logic [9:0] channel_bpm;
    logic [7:0] pulse_ms;
    logic [3:0] pulse_mask;
    logic [9:0] new_bpm;
    logic       tempo_set;
  } beat_result_t;

  // Mirror of the channel state and the registers, plus the queue of results
  // still to come from the block.
  class beat_clock_scoreboard;
    logic [9:0]   min_bpm;
    logic [9:0]   max_bpm;
    logic [7:0]   pulse_len;
    logic [3:0]   catchup;
    logic [7:0]   taps [NUM_CHANNELS];
    logic [31:0]  last_tap [NUM_CHANNELS];
    logic [9:0]   bpm [NUM_CHANNELS];
    logic [31:0]  next_beat [NUM_CHANNELS];
    beat_result_t expected_q [$];
    int           mismatches;

    function new();
      min_bpm    = MIN_BPM_RST;
      max_bpm    = MAX_BPM_RST;
      pulse_len  = PULSE_LEN_RST;
      catchup    = CATCHUP_RST;
      mismatches = 0;
      for (int c = 0; c < NUM_CHANNELS; c++) clear_channel(c);
    endfunction

    function void clear_channel(int c);
      taps[c]      = '0;
      last_tap[c]  = '0;
      bpm[c]       = '0;
      next_beat[c] = '0;
    endfunction

    function void write_register(logic [1:0] idx, logic [9:0] value);
      case (idx)
        REG_MIN_BPM:   min_bpm = value;
        REG_MAX_BPM:   max_bpm = value;
        REG_PULSE_LEN: pulse_len = value[7:0];
        REG_CATCHUP:   catchup = value[3:0];
        default: ;
      endcase
    endfunction

    // A tap returns the tempo it stored, or zero.
    function logic [9:0] apply_tap(int c, logic [31:0] now);
      logic [31:0] interval;
      logic [31:0] rate;
      if (taps[c] == 0 || now < last_tap[c]) begin
        taps[c]     = 8'd1;
        last_tap[c] = now;
        return '0;
      end
      interval    = now - last_tap[c];
      last_tap[c] = now;
      if (taps[c] != TAP_COUNT_MAX) taps[c] = taps[c] + 8'd1;
      if (interval == 0) begin
        taps[c] = 8'd1;
        return '0;
      end
      rate = MINUTE_MS / interval;
      if (rate < min_bpm || rate > max_bpm || rate == 0) begin
        taps[c] = 8'd1;
        return '0;
      end
      if (taps[c] < 2) return '0;
      bpm[c]       = rate[9:0];
      next_beat[c] = now + MINUTE_MS / rate;
      return rate[9:0];
    endfunction

    // A tick pulses every enabled channel whose beat is due and moves its beat.
    function logic [3:0] apply_tick(logic [31:0] now, logic [3:0] mask);
      logic [31:0] lag;
      logic [31:0] period;
      logic [3:0]  pulses;
      pulses = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (!mask[c] || bpm[c] == 0) continue;
        lag = now - next_beat[c];
        if (lag[31]) continue;
        period    = MINUTE_MS / bpm[c];
        pulses[c] = 1'b1;
        if (lag > period * catchup) next_beat[c] = now + period;
        else next_beat[c] = next_beat[c] + period;
      end
      return pulses;
    endfunction

    function void note_item(ttbc_func_t func, logic [1:0] ch, logic [31:0] now,
                            logic [3:0] mask);
      beat_result_t r;
      r = '0;
      case (func)
        FUNC_TAP: begin
          r.new_bpm = apply_tap(ch, now);
          if (r.new_bpm != 0) begin
            r.tempo_set     = 1'b1;
            r.pulse_mask[ch] = 1'b1;
          end
        end
        FUNC_TICK:      r.pulse_mask = apply_tick(now, mask);
        FUNC_DISABLE:   clear_channel(ch);
        FUNC_RESET_ALL: for (int c = 0; c < NUM_CHANNELS; c++) clear_channel(c);
        default: ;
      endcase
      if (r.pulse_mask != 0) r.pulse_ms = pulse_len;
      r.channel_bpm = bpm[ch];
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (mask[c] && bpm[c] != 0) begin
          r.any_bpm = bpm[c];
          break;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void report_mismatch(string text);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, text);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got)
        report_mismatch($sformatf("%s expected %0d, actual %0d", name, want, got));
    endfunction

    function void check_result(logic [47:0] data);
      beat_result_t got;
      beat_result_t want;
      got = data[$bits(beat_result_t)-1:0];
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with no item pending", data));
        return;
      end
      want = expected_q.pop_front();
      compare_field("tempo_set", want.tempo_set, got.tempo_set);
      compare_field("new_bpm", want.new_bpm, got.new_bpm);
      compare_field("led_pulse_mask", want.pulse_mask, got.pulse_mask);
      compare_field("pulse_ms", want.pulse_ms, got.pulse_ms);
      compare_field("channel_bpm", want.channel_bpm, got.channel_bpm);
      compare_field("any_bpm", want.any_bpm, got.any_bpm);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  wire logic   s_tready;
  logic [39:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  wire logic   m_tvalid;
  logic        m_tready = 1'b0;
  wire logic [47:0] m_tdata;
  logic        wr_en    = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [9:0]  wr_data  = '0;

  beat_clock_scoreboard sb = new();

  // Stimulus state.
  int          send_idle_pct = 36;
  int          recv_idle_pct = 63;
  int          hold_order    = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  int          items_sent    = 0;
  logic [31:0] clock_ms      = '0;
  int unsigned cur_min       = MIN_BPM_RST;
  int unsigned cur_max       = MAX_BPM_RST;

  tap_tempo_beat_clock dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe register writes, accepted items and accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) sb.write_register(wr_index, wr_data);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready)
        sb.note_item(ttbc_func_t'(s_tuser), s_tdata[1:0], s_tdata[33:2], s_tdata[37:34]);
    end
  end

  // Result side: random stalls, or a long hold-off when one is ordered.
  always @(posedge clk) begin
    if (hold_order != hold_seen) begin
      hold_seen <= hold_order;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(ttbc_func_t func, logic [1:0] ch, logic [31:0] now,
                           logic [3:0] mask);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {2'b00, mask, now, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles; the block must be idle.
  task automatic configure(logic [9:0] min_v, logic [9:0] max_v, logic [9:0] plen_v,
                           logic [9:0] lag_v);
    logic [1:0] idx [4];
    logic [9:0] vals [4];
    idx  = '{REG_MIN_BPM, REG_MAX_BPM, REG_PULSE_LEN, REG_CATCHUP};
    vals = '{min_v, max_v, plen_v, lag_v};
    for (int i = 0; i < 4; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[i];
      wr_data  <= vals[i];
      @(posedge clk);
    end
    wr_en   <= 1'b0;
    cur_min = min_v;
    cur_max = max_v;
  endtask

  function automatic logic [3:0] random_mask();
    if ($urandom_range(1) == 0) return 4'hF;
    return 4'($urandom_range(15));
  endfunction

  // Tap interval for a tempo inside the current accepted range.
  function automatic logic [31:0] tempo_gap();
    int unsigned rate;
    int unsigned gap;
    if (cur_min > cur_max) return $urandom_range(2000, 40);
    rate = $urandom_range(cur_max, cur_min);
    gap  = 60000 / rate;
    if (60000 / gap > cur_max) gap++;
    return gap;
  endfunction

  // Steady taps on one channel, optionally with ticks between them.
  task automatic tap_burst(int count, logic [31:0] fixed_gap, bit with_ticks);
    logic [1:0]  ch;
    logic [31:0] gap;
    ch  = 2'($urandom_range(3));
    gap = (fixed_gap != 0) ? fixed_gap : tempo_gap();
    for (int k = 0; k < count; k++) begin
      if (fixed_gap == 0 && k > 1 && $urandom_range(3) == 0) gap = tempo_gap();
      send_item(FUNC_TAP, ch, clock_ms, random_mask());
      if (with_ticks) begin
        repeat ($urandom_range(2))
          send_item(FUNC_TICK, 2'($urandom_range(3)), clock_ms + $urandom_range(gap - 1),
                    random_mask());
      end
      clock_ms += gap;
    end
  endtask

  // Ticks as time moves on, with the odd long jump to force a resync.
  task automatic tick_run();
    int n;
    n = $urandom_range(6, 1);
    repeat (n) begin
      if ($urandom_range(9) == 0) clock_ms += $urandom_range(40000, 5000);
      else clock_ms += $urandom_range(700);
      send_item(FUNC_TICK, 2'($urandom_range(3)), clock_ms, random_mask());
    end
  endtask

  // Taps that break a sequence: time backwards, no interval, too fast, too slow.
  task automatic broken_tap();
    logic [1:0] ch;
    ch = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: send_item(FUNC_TAP, ch, clock_ms - $urandom_range(5000, 1), random_mask());
      1: begin
        send_item(FUNC_TAP, ch, clock_ms, random_mask());
        send_item(FUNC_TAP, ch, clock_ms, random_mask());
      end
      2: begin
        clock_ms += $urandom_range(30, 1);
        send_item(FUNC_TAP, ch, clock_ms, random_mask());
      end
      default: begin
        clock_ms += $urandom_range(200000, 3000);
        send_item(FUNC_TAP, ch, clock_ms, random_mask());
      end
    endcase
  endtask

  task automatic random_items(int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 40) tap_burst($urandom_range(4, 2), 0, 1'b1);
      else if (pick < 70) tick_run();
      else if (pick < 76)
        send_item(FUNC_DISABLE, 2'($urandom_range(3)), clock_ms, random_mask());
      else if (pick < 78)
        send_item(FUNC_RESET_ALL, 2'($urandom_range(3)), clock_ms, random_mask());
      else if (pick < 88) broken_tap();
      else begin
        // Noise: any function, any time stamp.
        if ($urandom_range(9) == 0) clock_ms = $urandom();
        send_item(ttbc_func_t'(2'($urandom_range(3))), 2'($urandom_range(3)), $urandom(),
                  4'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values.
    send_item(FUNC_TAP, 2'd0, 32'd0, 4'hF);              // first tap
    send_item(FUNC_TAP, 2'd0, 32'd0, 4'hF);              // no interval
    send_item(FUNC_TAP, 2'd0, 32'd1000, 4'h1);           // 60 bpm set
    send_item(FUNC_TAP, 2'd0, 32'd1001, 4'h1);           // far too fast
    send_item(FUNC_TAP, 2'd0, 32'd1501, 4'h0);           // 120 bpm set
    send_item(FUNC_TAP, 2'd1, 32'hFFFF_FF00, 4'hF);      // first tap, late time
    send_item(FUNC_TAP, 2'd1, 32'd100, 4'hF);            // time ran backwards
    send_item(FUNC_TAP, 2'd1, 32'd1600, 4'h2);           // lowest tempo, 40 bpm
    send_item(FUNC_TAP, 2'd2, 32'd1600, 4'h4);
    send_item(FUNC_TAP, 2'd2, 32'd1800, 4'h4);           // highest tempo, 300 bpm
    send_item(FUNC_TAP, 2'd3, 32'd1800, 4'h8);
    send_item(FUNC_TAP, 2'd3, 32'd1999, 4'h8);           // just above the range
    send_item(FUNC_TICK, 2'd0, 32'd1999, 4'hF);          // nothing due yet
    send_item(FUNC_TICK, 2'd2, 32'd2000, 4'h4);          // beat due with no lag
    send_item(FUNC_TICK, 2'd1, 32'd2001, 4'hF);          // beat moves one period
    send_item(FUNC_TICK, 2'd3, 32'd20000, 4'hF);         // long lag, resync to now
    send_item(FUNC_TICK, 2'd0, 32'd20000, 4'h0);         // nothing enabled
    send_item(FUNC_DISABLE, 2'd0, 32'd20000, 4'hF);
    send_item(FUNC_TAP, 2'd3, 32'hFFFF_FFFF, 4'hF);      // interval too long for a tempo
    send_item(FUNC_RESET_ALL, 2'd3, 32'd0, 4'hF);
    send_item(FUNC_TAP, 2'd3, 32'hFFFF_FF00, 4'h8);
    send_item(FUNC_TAP, 2'd3, 32'hFFFF_FFFF, 4'h8);      // next beat wraps past zero
    send_item(FUNC_TICK, 2'd3, 32'h0000_0100, 4'h8);     // due across the wrap
    wait_all_results();

    // Widest range, longest pulse, resync on any lag; one long result stall.
    configure(10'd1, 10'd1000, 10'd255, 10'd0);
    random_items(25);
    hold_order <= hold_order + 1;
    random_items(25);
    wait_all_results();

    // No tempo can be accepted while the lower bound is above the upper one.
    send_idle_pct = 63;
    recv_idle_pct = 36;
    configure(10'd1000, 10'd1, 10'd0, 10'd15);
    random_items(30);
    wait_all_results();

    // Narrow range, time starting close to the wrap.
    configure(10'd60, 10'd240, 10'd100, 10'd1);
    clock_ms = 32'hFFFF_F000;
    random_items(20);
    wait_all_results();
    random_items(20);
    wait_all_results();

    // No idling: a run long enough to saturate the tap count, then more mix.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(10'd30, 10'd600, 10'd1, 10'd7);
    tap_burst(260, 32'd500, 1'b0);
    send_item(FUNC_TICK, 2'd0, clock_ms, 4'hF);
    hold_order <= hold_order + 1;
    random_items(20);

    wait_all_results();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
